@@ src/ecs_pkg.sv @@
// shared constants and types for the edge coverage setup block
`timescale 1ns / 1ps
`default_nettype none
package ecs_pkg;

  // default widths of the position and fraction fields
  localparam int POSITION_BITS_DEF = 18;
  localparam int FRACTION_BITS_DEF = 16;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } ecs_qstat_t;

endpackage
`default_nettype wire

@@ src/ecs_front.sv @@
// front stage: takes an edge pair, orders it and classifies the crossing
`timescale 1ns / 1ps
`default_nettype none
module ecs_front #(
  parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [POSITION_BITS-1:0] edge_left_i,
  input  wire logic [POSITION_BITS-1:0] edge_right_i,
  input  wire ecs_pkg::ecs_qstat_t      qstat_i,
  output logic                          push_o,
  output logic [POSITION_BITS-1:0]      lo_o,
  output logic [POSITION_BITS-1:0]      d_o,
  output logic [5:0]                    lf_o,
  output logic [5:0]                    hf_o,
  output logic [11:0]                   hfsq_o,
  output logic                          same_o,
  output logic                          zero_o
);

  logic                     accept;
  logic                     valid_q, valid_d;
  logic                     swap;
  logic [POSITION_BITS-1:0] lo_d, hi_d;
  logic [POSITION_BITS-1:0] lo_q, d_q;
  logic [5:0]               lf_q, hf_q;
  logic [11:0]              hfsq_q;
  logic                     same_q, zero_q;

  assign push_o = valid_q && !qstat_i.full;
  assign busy   = valid_q && qstat_i.full;
  assign accept = start && !busy;

  assign swap = edge_left_i > edge_right_i;
  assign lo_d = swap ? edge_right_i : edge_left_i;
  assign hi_d = swap ? edge_left_i : edge_right_i;

  assign valid_d = accept ? 1'b1 : (push_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q   <= lo_d;
      d_q    <= hi_d - lo_d;
      lf_q   <= lo_d[5:0];
      hf_q   <= hi_d[5:0];
      hfsq_q <= {6'd0, hi_d[5:0]} * {6'd0, hi_d[5:0]};
      same_q <= lo_d[POSITION_BITS-1:6] == hi_d[POSITION_BITS-1:6];
      zero_q <= lo_d == hi_d;
    end
  end

  assign lo_o   = lo_q;
  assign d_o    = d_q;
  assign lf_o   = lf_q;
  assign hf_o   = hf_q;
  assign hfsq_o = hfsq_q;
  assign same_o = same_q;
  assign zero_o = zero_q;

  // a held item keeps its payload until the queue takes it
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !push_o |=> valid_q && $stable(lo_q) && $stable(d_q))
    else $error("front item changed while waiting for the queue");

endmodule
`default_nettype wire

@@ src/ecs_queue.sv @@
// short queue between the front and back stages
`timescale 1ns / 1ps
`default_nettype none
module ecs_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [WIDTH-1:0]    data_i,
  input  wire logic                pop_i,
  output logic [WIDTH-1:0]         data_o,
  output ecs_pkg::ecs_qstat_t      stat_o
);

  logic [WIDTH-1:0]               mem_q [ecs_pkg::QUEUE_DEPTH];
  logic [ecs_pkg::QPTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ecs_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  localparam logic [ecs_pkg::QPTR_W-1:0] LAST = ecs_pkg::QPTR_W'(ecs_pkg::QUEUE_DEPTH - 1);

  assign stat_o.full  = cnt_q == ecs_pkg::QCNT_W'(ecs_pkg::QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign data_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !stat_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

@@ src/ecs_div.sv @@
// pipelined restoring divider, one quotient bit per stage, for (64 << F) / d
`timescale 1ns / 1ps
`default_nettype none
module ecs_div #(
  parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF,
  parameter int FRACTION_BITS = ecs_pkg::FRACTION_BITS_DEF,
  parameter int SIDE_W        = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [POSITION_BITS-1:0]    divisor_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic [FRACTION_BITS+6:0]         quotient_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int P = POSITION_BITS;
  localparam int N = FRACTION_BITS + 7;
  localparam logic [N-1:0] DIVIDEND = N'(1) << (FRACTION_BITS + 6);

  logic [P-1:0]      rem_q  [N];
  logic [N-1:0]      quo_q  [N];
  logic [P-1:0]      dvs_q  [N];
  logic [SIDE_W-1:0] side_q [N];
  logic              vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [P-1:0]      rem_in;
    logic [N-1:0]      quo_in;
    logic [P-1:0]      dvs_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [P:0]        trial;
    logic [P+1:0]      diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next dividend bit, subtract when it fits
    assign trial = {rem_in, DIVIDEND[N-1-k]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_in};
    assign ge    = !diff[P+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[P-1:0] : trial[P-1:0];
      quo_q[k]  <= {quo_in[N-2:0], ge};
      dvs_q[k]  <= dvs_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o    = vld_q[N-1];
  assign quotient_o = quo_q[N-1];
  assign side_o     = side_q[N-1];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##N valid_o)
    else $error("divider lost an item");

endmodule
`default_nettype wire

@@ src/ecs_back.sv @@
// back part: increment divide, coverage products and adder assembly
`timescale 1ns / 1ps
`default_nettype none
module ecs_back #(
  parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF,
  parameter int FRACTION_BITS = ecs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [POSITION_BITS-1:0]        lo_i,
  input  wire logic [POSITION_BITS-1:0]        d_i,
  input  wire logic [5:0]                      lf_i,
  input  wire logic [5:0]                      hf_i,
  input  wire logic [11:0]                     hfsq_i,
  input  wire logic                            same_i,
  input  wire logic                            zero_i,
  output logic                                 valid_o,
  output logic [POSITION_BITS-1:0]             begin_position_o,
  output logic [FRACTION_BITS+6:0]             coverage_increment_o,
  output logic signed [FRACTION_BITS+8:0]      begin_adder_o,
  output logic signed [FRACTION_BITS+8:0]      end_adder_o
);

  localparam int P      = POSITION_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int N      = F + 7;
  localparam int ADD_W  = F + 9;
  localparam int SIDE_W = P + 32;
  localparam int SH_W   = F + 21;
  localparam logic [N-1:0] INC_EQ = N'(100) << F;

  // divider
  logic              div_vld;
  logic [N-1:0]      div_quo;
  logic [SIDE_W-1:0] div_side;
  logic [P-1:0]      s_lo;
  logic [5:0]        s_dh, s_lf, s_hf;
  logic [11:0]       s_hfsq;
  logic              s_same, s_zero;

  ecs_div #(
    .POSITION_BITS(P),
    .FRACTION_BITS(F),
    .SIDE_W       (SIDE_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .divisor_i (d_i),
    .side_i    ({lo_i, d_i[6:1], lf_i, hf_i, hfsq_i, same_i, zero_i}),
    .valid_o   (div_vld),
    .quotient_o(div_quo),
    .side_o    (div_side)
  );

  assign {s_lo, s_dh, s_lf, s_hf, s_hfsq, s_same, s_zero} = div_side;

  // stage a: equal positions take the fixed increment
  logic         a_vld_q;
  logic [N-1:0] a_inc_q;
  logic [P-1:0] a_lo_q;
  logic [5:0]   a_dh_q, a_lf_q, a_hf_q;
  logic [11:0]  a_hfsq_q;
  logic         a_same_q;

  // stage b: products of the increment
  logic [6:0]    b_h_d;
  logic          b_vld_q;
  logic [N+5:0]  b_plf_q, b_phf_q;
  logic [N+6:0]  b_ph_q;
  logic [N+11:0] b_phf2_q;
  logic [6:0]    b_h_q;
  logic [5:0]    b_dh_q, b_hf_q;
  logic [P-1:0]  b_lo_q;
  logic [N-1:0]  b_inc_q;
  logic          b_same_q;

  // stage c: width times height, same-pixel and end terms
  logic [13:0]      c_w;
  logic [6:0]       c_sum7;
  logic [ADD_W-1:0] c_a, c_b;
  logic             c_vld_q;
  logic [20:0]      c_hw_q;
  logic [ADD_W-1:0] c_abeg_q, c_fpcs_q, c_end_q;
  logic [P-1:0]     c_lo_q;
  logic [N-1:0]     c_inc_q;
  logic             c_same_q;

  // stage d: final sums
  logic [SH_W-1:0]  d_sh;
  logic [ADD_W-1:0] d_fpc, d_beg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      a_vld_q <= div_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      valid_o <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_inc_q  <= s_zero ? INC_EQ : div_quo;
    a_lo_q   <= s_lo;
    a_dh_q   <= s_dh;
    a_lf_q   <= s_lf;
    a_hf_q   <= s_hf;
    a_hfsq_q <= s_hfsq;
    a_same_q <= s_same;
  end

  assign b_h_d = 7'd64 - {1'b0, a_lf_q};

  always_ff @(posedge clk_i) begin
    b_plf_q  <= (N+6)'(a_inc_q) * (N+6)'(a_lf_q);
    b_phf_q  <= (N+6)'(a_inc_q) * (N+6)'(a_hf_q);
    b_ph_q   <= (N+7)'(a_inc_q) * (N+7)'(b_h_d);
    b_phf2_q <= (N+12)'(a_inc_q) * (N+12)'(a_hfsq_q);
    b_h_q    <= b_h_d;
    b_dh_q   <= a_dh_q;
    b_hf_q   <= a_hf_q;
    b_lo_q   <= a_lo_q;
    b_inc_q  <= a_inc_q;
    b_same_q <= a_same_q;
  end

  assign c_w    = b_ph_q[F+13:F];
  assign c_sum7 = (7'd64 - {1'b0, b_hf_q}) + {1'b0, b_dh_q};
  assign c_a    = ADD_W'(b_phf_q[N+5:6]);
  assign c_b    = ADD_W'(b_phf2_q[N+11:13]);

  always_ff @(posedge clk_i) begin
    c_hw_q   <= 21'(b_h_q) * 21'(c_w);
    c_abeg_q <= ADD_W'(b_plf_q[N+5:6]);
    c_fpcs_q <= ADD_W'({c_sum7, {(F-6){1'b0}}});
    c_end_q  <= c_a - c_b;
    c_lo_q   <= b_lo_q;
    c_inc_q  <= b_inc_q;
    c_same_q <= b_same_q;
  end

  assign d_sh  = {c_hw_q, {F{1'b0}}} >> 13;
  assign d_fpc = c_same_q ? c_fpcs_q : d_sh[ADD_W-1:0];
  assign d_beg = c_abeg_q + d_fpc;

  always_ff @(posedge clk_i) begin
    begin_position_o     <= c_lo_q;
    coverage_increment_o <= c_inc_q;
    begin_adder_o        <= d_beg;
    end_adder_o          <= c_same_q ? d_beg : c_end_q;
  end

endmodule
`default_nettype wire

@@ src/edge_coverage_setup_top.sv @@
// top level of the edge coverage setup block
//
//   channel  | ports                                   | transfer when
//   ---------+-----------------------------------------+--------------------
//   input    | edge_left_i, edge_right_i               | start && !busy
//   result   | begin_position_o, coverage_increment_o, | valid_o (one cycle)
//            | begin_adder_o, end_adder_o              |
//
// one edge pair per cycle sustained; an input pair passes the front register, the
// queue, the divider stages, back stages a, b and c and the output register before
// its result strobe rises
// most of that depth is in the increment divider, which resolves one quotient bit
// per pipeline stage
// asynchronous active-low reset empties every stage and the queue
// the result side cannot stall; busy only rises if the queue fills, which
// the back part never lets happen since it drains one entry every cycle
`timescale 1ns / 1ps
`default_nettype none
module edge_coverage_setup_top #(
  parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF,
  parameter int FRACTION_BITS = ecs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [POSITION_BITS-1:0]      edge_left_i,
  input  wire logic [POSITION_BITS-1:0]      edge_right_i,
  output logic                               valid_o,
  output logic [POSITION_BITS-1:0]           begin_position_o,
  output logic [FRACTION_BITS+6:0]           coverage_increment_o,
  output logic signed [FRACTION_BITS+8:0]    begin_adder_o,
  output logic signed [FRACTION_BITS+8:0]    end_adder_o
);

  // queued item: low position, difference, fractions, classification
  localparam int ITEM_W = 2 * POSITION_BITS + 26;

  ecs_pkg::ecs_qstat_t       qstat;
  logic                      push, pop;
  logic [POSITION_BITS-1:0]  f_lo, f_d, q_lo, q_d;
  logic [5:0]                f_lf, f_hf, q_lf, q_hf;
  logic [11:0]               f_hfsq, q_hfsq;
  logic                      f_same, f_zero, q_same, q_zero;
  logic [ITEM_W-1:0]         q_item;

  // front orders the pair and flags same-pixel and equal positions
  ecs_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .edge_left_i (edge_left_i),
    .edge_right_i(edge_right_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .lo_o        (f_lo),
    .d_o         (f_d),
    .lf_o        (f_lf),
    .hf_o        (f_hf),
    .hfsq_o      (f_hfsq),
    .same_o      (f_same),
    .zero_o      (f_zero)
  );

  // back drains the queue every cycle it holds something
  assign pop = !qstat.empty;

  ecs_queue #(
    .WIDTH(ITEM_W)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i({f_lo, f_d, f_lf, f_hf, f_hfsq, f_same, f_zero}),
    .pop_i (pop),
    .data_o(q_item),
    .stat_o(qstat)
  );

  assign {q_lo, q_d, q_lf, q_hf, q_hfsq, q_same, q_zero} = q_item;

  // back: divider pipeline, then products and adder sums
  ecs_back #(
    .POSITION_BITS(POSITION_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (pop),
    .lo_i                (q_lo),
    .d_i                 (q_d),
    .lf_i                (q_lf),
    .hf_i                (q_hf),
    .hfsq_i              (q_hfsq),
    .same_i              (q_same),
    .zero_i              (q_zero),
    .valid_o             (valid_o),
    .begin_position_o    (begin_position_o),
    .coverage_increment_o(coverage_increment_o),
    .begin_adder_o       (begin_adder_o),
    .end_adder_o         (end_adder_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the edge coverage setup block
`timescale 1ns / 1ps
module tb_top;

  // widths at the block's default configuration
  localparam int PB = ecs_pkg::POSITION_BITS_DEF;
  localparam int FB = ecs_pkg::FRACTION_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  // input to result distance, plus slack for the drain at the end
  localparam int LATENCY     = FB + 13;
  localparam int DRAIN_LIMIT = 2000;
  localparam int PHASE_ITEMS = 500;
  localparam int N_DIRECTED  = 20;

  // one expected result, field by field at port widths
  typedef struct packed {
    logic [PB-1:0] pos;
    logic [FB+6:0] inc;
    logic [FB+8:0] beg_add;
    logic [FB+8:0] fin_add;
  } coverage_t;

  // one row of the directed table; fixed_exp marks rows whose result is typed in
  typedef struct packed {
    logic [PB-1:0] left;
    logic [PB-1:0] right;
    logic          fixed_exp;
    coverage_t     exp;
  } dir_row_t;

  // shapes of random edge pairs
  typedef enum int {
    PAIR_EQUAL,
    PAIR_SAME_PIXEL,
    PAIR_SHORT_SPAN,
    PAIR_BOUNDARY,
    PAIR_ANY
  } pair_kind_e;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // equal positions: increment takes the fixed 100.0, same-pixel path
    '{18'd0,      18'd0,      1'b1, '{18'd0,      23'd6553600, 25'd65536,   25'd65536}},
    '{18'd262143, 18'd262143, 1'b1, '{18'd262143, 23'd6553600, 25'd6452224, 25'd6452224}},
    // exactly one pixel apart, both orders: unit increment, zero end adder
    '{18'd0,      18'd64,     1'b1, '{18'd0,      23'd65536,   25'd32768,   25'd0}},
    '{18'd64,     18'd0,      1'b1, '{18'd0,      23'd65536,   25'd32768,   25'd0}},
    // widest span and smallest span, both orders
    '{18'd0,      18'd262143, 1'b0, '0},
    '{18'd262143, 18'd0,      1'b0, '0},
    '{18'd0,      18'd1,      1'b0, '0},
    '{18'd1,      18'd0,      1'b0, '0},
    // same pixel with distinct fractions
    '{18'd5,      18'd60,     1'b0, '0},
    '{18'd60,     18'd5,      1'b0, '0},
    '{18'd64,     18'd127,    1'b0, '0},
    '{18'd262080, 18'd262143, 1'b0, '0},
    // spanning across one boundary by a single step
    '{18'd63,     18'd64,     1'b0, '0},
    '{18'd127,    18'd128,    1'b0, '0},
    '{18'd131072, 18'd131071, 1'b0, '0},
    // spanning with fractions on both ends
    '{18'd10,     18'd200,    1'b0, '0},
    '{18'd200,    18'd10,     1'b0, '0},
    // alternating and complementary bit patterns
    '{18'h2AAAA,  18'h15555,  1'b0, '0},
    '{18'h15555,  18'h2AAAA,  1'b0, '0},
    '{18'h3FFC0,  18'h0003F,  1'b0, '0}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [PB-1:0] edge_left_i = '0;
  logic [PB-1:0] edge_right_i = '0;
  logic          valid_o;
  logic [PB-1:0] begin_position_o;
  logic [FB+6:0] coverage_increment_o;
  logic signed [FB+8:0] begin_adder_o;
  logic signed [FB+8:0] end_adder_o;

  // results still owed by the block, oldest first
  coverage_t pending_coverage [$];

  int errors = 0;
  int items_sent = 0;
  int spans_sent = 0;
  int results_seen = 0;

  edge_coverage_setup_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .edge_left_i         (edge_left_i),
    .edge_right_i        (edge_right_i),
    .valid_o             (valid_o),
    .begin_position_o    (begin_position_o),
    .coverage_increment_o(coverage_increment_o),
    .begin_adder_o       (begin_adder_o),
    .end_adder_o         (end_adder_o)
  );

  always #5 clk_i = ~clk_i;

  // coverage setup for one edge pair, computed wide and cut to port widths
  function automatic coverage_t coverage_setup(input logic [PB-1:0] left,
                                               input logic [PB-1:0] right);
    longint unsigned lo, hi, span, step, lf, hf, head, whole, first_cov;
    longint beg_add, fin_add;
    coverage_t res;
    lo = 64'((left > right) ? right : left);
    hi = 64'((left > right) ? left : right);
    span = hi - lo;
    // equal positions give the fixed 100.0 increment
    step = (span == 64'd0) ? (64'd100 << FB) : ((64'd64 << FB) / span);
    lf = lo & 64'd63;
    hf = hi & 64'd63;
    if ((lo >> 6) == (hi >> 6)) begin
      // both ends inside one pixel
      first_cov = ((64'd64 - hf) + (span >> 1)) << (FB - 6);
      beg_add = longint'(((step * lf) >> 6) + first_cov);
      fin_add = beg_add;
    end else begin
      // edge crosses pixels; whole is the run width cut to an integer
      head = 64'd64 - lf;
      whole = (step * head) >> FB;
      first_cov = ((head * whole) << FB) >> 13;
      beg_add = longint'(((step * lf) >> 6) + first_cov);
      fin_add = (ONE - longint'((hf * hf * step) >> 13))
              - (ONE - longint'((hf * step) >> 6));
    end
    res.pos = lo[PB-1:0];
    res.inc = step[FB+6:0];
    res.beg_add = beg_add[FB+8:0];
    res.fin_add = fin_add[FB+8:0];
    return res;
  endfunction

  // one input transfer with a random lead-in gap; the expectation is queued
  // at the edge that takes the pair
  task automatic send_pair(input logic [PB-1:0] left, input logic [PB-1:0] right,
                           input int idle_pct, input logic use_fixed,
                           input coverage_t fixed_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    edge_left_i <= left;
    edge_right_i <= right;
    do @(posedge clk_i); while (busy);
    pending_coverage.push_back(use_fixed ? fixed_res : coverage_setup(left, right));
    items_sent++;
    if (left[PB-1:6] != right[PB-1:6]) spans_sent++;
  endtask

  task automatic report_field(input string field, input longint exp_val,
                              input longint act_val);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, exp_val, act_val);
    errors++;
  endtask

  // result side: every strobe is a transfer, checked against the oldest entry
  always @(posedge clk_i) begin
    coverage_t exp;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_coverage.size() == 0) begin
        $display("%0t unexpected result: position %0d, increment %0d", $time,
                 begin_position_o, coverage_increment_o);
        errors++;
      end else begin
        exp = pending_coverage.pop_front();
        if (begin_position_o !== exp.pos)
          report_field("begin_position", exp.pos, begin_position_o);
        if (coverage_increment_o !== exp.inc)
          report_field("coverage_increment", exp.inc, coverage_increment_o);
        if (begin_adder_o !== exp.beg_add)
          report_field("begin_adder", $signed(exp.beg_add), begin_adder_o);
        if (end_adder_o !== exp.fin_add)
          report_field("end_adder", $signed(exp.fin_add), end_adder_o);
      end
    end
  end

  // stimulus: directed table, then three random phases with different idling
  initial begin
    logic [PB-1:0] left, right, base;
    pair_kind_e kind;
    int idle_pct;
    int guard;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; typed results where they are obvious, predictor otherwise
    foreach (DIRECTED[i])
      send_pair(DIRECTED[i].left, DIRECTED[i].right, 7, DIRECTED[i].fixed_exp,
                DIRECTED[i].exp);

    for (int phase = 0; phase < 3; phase++) begin
      // sender idles rarely, then mostly, then never
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 76 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = pair_kind_e'($urandom_range(PAIR_ANY));
        left = PB'($urandom);
        right = PB'($urandom);
        case (kind)
          PAIR_EQUAL: begin
            right = left;
          end
          PAIR_SAME_PIXEL: begin
            base = {left[PB-1:6], 6'd0};
            left = base | PB'($urandom_range(63));
            right = base | PB'($urandom_range(63));
          end
          PAIR_SHORT_SPAN: begin
            // a few pixels apart; wraps at the top of the range
            right = left + PB'($urandom_range(1, 400));
            if ($urandom_range(1)) {left, right} = {right, left};
          end
          PAIR_BOUNDARY: begin
            // pixel edges and the ends of the range
            case ($urandom_range(3))
              0: left = '0;
              1: left = '1;
              2: left = {left[PB-1:6], 6'd0};
              default: left = {left[PB-1:6], 6'd63};
            endcase
            right = {right[PB-1:6], $urandom_range(1) ? 6'd0 : 6'd63};
          end
          default: begin
          end
        endcase
        send_pair(left, right, idle_pct, 1'b0, '0);
      end
      // hold off until the block has returned everything in flight
      start <= 1'b0;
      @(posedge clk_i);
      while (pending_coverage.size() != 0) @(posedge clk_i);
    end

    start <= 1'b0;
    guard = 0;
    while (pending_coverage.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_coverage.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_coverage.size());
      errors++;
    end
    // catch stray strobes after the last expected result
    repeat (LATENCY + 16) @(posedge clk_i);

    $display("sent %0d edge pairs (%0d spanning pixels, rest within one pixel)",
             items_sent, spans_sent);
    $display("checked %0d results under three sender idle rates", results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
